/* hdl/tsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt sensor conditioner package
// Shared widths, register codes, reset values, state types, the lane
// request/response structs and the saturating sample arithmetic.
// ----------------------------------------------------------------------------
package tsc_pkg;

  // Sample and band widths.
  localparam int SampleBits  = 16;
  localparam int NumAxes     = 3;
  localparam int MaxBands    = 32;
  localparam int BandBits    = $clog2(MaxBands + 1);
  localparam int ProdBits    = SampleBits + BandBits;
  localparam int StepBits    = $clog2(SampleBits);
  localparam int CountBits   = 6;

  // Port widths.
  localparam int InDataBits  = NumAxes * SampleBits;
  localparam int OutDataBits = 2 * NumAxes * SampleBits;
  localparam int CfgAddrBits = 3;
  localparam int CfgDataBits = NumAxes * SampleBits;

  // Register reset values: 10 degree step limits, 60/60/90 degree spans.
  localparam logic [CfgDataBits-1:0] StepLimitsReset = 48'h0280_0280_0280;
  localparam logic [CfgDataBits-1:0] OutputSpanReset = 48'h1680_0F00_0F00;
  localparam logic [CountBits-1:0]   DivideCountReset = 6'd5;

  typedef logic signed [SampleBits-1:0] sample_t;

  localparam logic signed [SampleBits:0] WideMax = (SampleBits + 1)'((2 ** (SampleBits - 1)) - 1);
  localparam logic signed [SampleBits:0] WideMin = (SampleBits + 1)'(-(2 ** (SampleBits - 1)));
  localparam sample_t SampleMax = SampleBits'((2 ** (SampleBits - 1)) - 1);
  localparam sample_t SampleMin = SampleBits'(-(2 ** (SampleBits - 1)));

  // Configuration register indexes.
  typedef enum logic [CfgAddrBits-1:0] {
    CFG_AXIS_OFFSETS     = 3'd0,
    CFG_DEADZONES        = 3'd1,
    CFG_STEP_LIMITS      = 3'd2,
    CFG_FREEZE_THRESHOLD = 3'd3,
    CFG_FLIP_MASK        = 3'd4,
    CFG_MAX_INCLINE      = 3'd5,
    CFG_DIVIDE_COUNT     = 3'd6,
    CFG_OUTPUT_SPAN      = 3'd7
  } cfg_idx_e;

  // Top-level sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COND,
    ST_LIMIT,
    ST_START,
    ST_WAIT,
    ST_OUT
  } top_state_e;

  // Band lane states.
  typedef enum logic [2:0] {
    LN_IDLE,
    LN_PREP,
    LN_SEARCH,
    LN_SCALE,
    LN_DIVIDE,
    LN_DONE
  } lane_state_e;

  // Conditioning stage enables.
  typedef struct packed {
    logic stage1_en;
    logic stage2_en;
  } cond_ctrl_t;

  // Work handed to one band lane.
  typedef struct packed {
    logic                  start;
    sample_t               value;
    logic [SampleBits-1:0] incline;
    logic [SampleBits-1:0] span;
    logic [BandBits-1:0]   bands;
  } band_req_t;

  // Result returned by one band lane.
  typedef struct packed {
    logic    done;
    sample_t level;
  } band_rsp_t;

  // Clamp a one-bit-wider signed value to the sample range.
  function automatic sample_t sat_sample(input logic signed [SampleBits:0] v);
    sample_t r;
    if (v > WideMax) begin
      r = SampleMax;
    end else if (v < WideMin) begin
      r = SampleMin;
    end else begin
      r = v[SampleBits-1:0];
    end
    return r;
  endfunction

  // Saturating negation.
  function automatic sample_t neg_sat(input sample_t a);
    logic signed [SampleBits:0] w;
    w = -$signed({a[SampleBits-1], a});
    return sat_sample(w);
  endfunction

  // Saturating difference a - b.
  function automatic sample_t sub_sat(input sample_t a, input sample_t b);
    logic signed [SampleBits:0] w;
    w = $signed({a[SampleBits-1], a}) - $signed({b[SampleBits-1], b});
    return sat_sample(w);
  endfunction

  // Unsigned distance |a - b|; always fits in SampleBits unsigned bits.
  function automatic logic [SampleBits-1:0] abs_diff(input sample_t a, input sample_t b);
    logic signed [SampleBits:0] d;
    logic signed [SampleBits:0] n;
    d = $signed({a[SampleBits-1], a}) - $signed({b[SampleBits-1], b});
    n = -d;
    return d[SampleBits] ? n[SampleBits-1:0] : d[SampleBits-1:0];
  endfunction

endpackage

/* hdl/tsc_cond.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt sensor conditioner front end
// Two register stages: flip, offset and deadzone, then the step limit, the
// z freeze and the hold on a failed read. Keeps the previous raw sample.
// ----------------------------------------------------------------------------
module tsc_cond (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tsc_pkg::cond_ctrl_t                 ctrl_i,
  input  tsc_pkg::sample_t                    sample_i [tsc_pkg::NumAxes],
  input  logic                                read_ok_i,
  input  logic [tsc_pkg::CfgDataBits-1:0]     offsets_i,
  input  logic [tsc_pkg::CfgDataBits-1:0]     deadzones_i,
  input  logic [tsc_pkg::CfgDataBits-1:0]     step_limits_i,
  input  logic [tsc_pkg::SampleBits-1:0]      freeze_i,
  input  logic [tsc_pkg::NumAxes-1:0]         flip_i,
  output tsc_pkg::sample_t                    result_o [tsc_pkg::NumAxes]
);

  localparam int SB = tsc_pkg::SampleBits;
  localparam int NA = tsc_pkg::NumAxes;

  tsc_pkg::sample_t raw_q  [NA];
  tsc_pkg::sample_t cond_q [NA];
  tsc_pkg::sample_t prev_q [NA];
  tsc_pkg::sample_t res_q  [NA];
  logic             primed_q;

  tsc_pkg::sample_t flip_w  [NA];
  tsc_pkg::sample_t cond_w  [NA];
  tsc_pkg::sample_t lim_w   [NA];
  logic [SB-1:0]    move_w  [NA];
  logic             freeze_w;

  // Per-axis datapath for both stages.
  for (genvar a = 0; a < NA; a++) begin : g_axis
    tsc_pkg::sample_t off_w;
    tsc_pkg::sample_t sub_w;
    tsc_pkg::sample_t base_w;
    logic [SB-1:0]    dz_w;
    logic [SB-1:0]    dist_w;
    logic             over_w;

    // Stage 1: optional negation, offset removal and deadzone.
    assign off_w     = tsc_pkg::sample_t'(offsets_i[SB*a +: SB]);
    assign dz_w      = deadzones_i[SB*a +: SB];
    assign flip_w[a] = flip_i[a] ? tsc_pkg::neg_sat(sample_i[a]) : sample_i[a];
    assign sub_w     = tsc_pkg::sub_sat(flip_w[a], off_w);
    assign cond_w[a] = (tsc_pkg::abs_diff(sub_w, '0) < dz_w) ? '0 : sub_w;

    // Stage 2: until primed, the comparison base is the value itself.
    assign base_w    = primed_q ? prev_q[a] : cond_q[a];
    assign dist_w    = tsc_pkg::abs_diff(base_w, cond_q[a]);
    assign over_w    = dist_w > step_limits_i[SB*a +: SB];
    assign lim_w[a]  = over_w ? base_w : cond_q[a];
    assign move_w[a] = over_w ? '0 : dist_w;
  end

  // A large z change clears x and y.
  assign freeze_w = move_w[2] >= freeze_i;

  // Stage 1 registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.stage1_en) begin
      for (int a = 0; a < NA; a++) begin
        raw_q[a]  <= flip_w[a];
        cond_q[a] <= cond_w[a];
      end
    end
  end

  // Stage 2 result; a failed read repeats the stored raw sample.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.stage2_en) begin
      if (read_ok_i) begin
        res_q[0] <= freeze_w ? '0 : lim_w[0];
        res_q[1] <= freeze_w ? '0 : lim_w[1];
        res_q[2] <= lim_w[2];
      end else begin
        for (int a = 0; a < NA; a++) begin
          res_q[a] <= prev_q[a];
        end
      end
    end
  end

  // Previous raw sample and primed flag advance on good reads only.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NA; a++) begin
        prev_q[a] <= '0;
      end
      primed_q <= 1'b0;
    end else if (ctrl_i.stage2_en && read_ok_i) begin
      for (int a = 0; a < NA; a++) begin
        prev_q[a] <= raw_q[a];
      end
      primed_q <= 1'b1;
    end
  end

  assign result_o = res_q;

endmodule

/* hdl/tsc_band_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt sensor conditioner band lane
// Finds the incline band of one axis value and scales it to the output span.
// Band search and quotient search each resolve one bit per cycle.
// ----------------------------------------------------------------------------
module tsc_band_lane (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tsc_pkg::band_req_t    req_i,
  output tsc_pkg::band_rsp_t    rsp_o
);

  localparam int SB = tsc_pkg::SampleBits;
  localparam int BB = tsc_pkg::BandBits;
  localparam int PB = tsc_pkg::ProdBits;
  localparam int CB = tsc_pkg::StepBits;

  tsc_pkg::lane_state_e state_q, state_d;

  logic [CB-1:0] cnt_q;
  logic          neg_q;
  logic [SB-1:0] mag_q;
  logic [SB-1:0] incline_q;
  logic [SB-1:0] span_q;
  logic [BB-1:0] bands_q;
  logic [PB-1:0] target_q;
  logic [BB-1:0] band_q;
  logic [PB-1:0] scaled_q;
  logic [SB-1:0] quo_q;

  logic [SB-1:0] mag_in;
  logic [PB-1:0] target_prod;
  logic [BB-1:0] band_try;
  logic [PB-1:0] band_prod;
  logic [BB:0]   band_inc;
  logic [BB-1:0] band_idx;
  logic [PB-1:0] scale_prod;
  logic [SB-1:0] quo_try;
  logic [PB-1:0] quo_prod;
  logic [SB-1:0] level_mag;

  // Magnitude of the incoming value.
  assign mag_in = tsc_pkg::abs_diff(req_i.value, '0);

  // X = |v| * d, the threshold that band * incline must reach.
  assign target_prod = PB'(mag_q) * PB'(bands_q);

  // Largest band_q with band_q * incline below X; the band is one more.
  assign band_try  = band_q | (BB'(1) << cnt_q);
  assign band_prod = PB'(band_try) * PB'(incline_q);
  assign band_inc  = {1'b0, band_q} + (BB + 1)'(1);
  assign band_idx  = (band_inc > {1'b0, bands_q}) ? bands_q : band_inc[BB-1:0];

  // Quotient floor(band * span / d), built MSB first.
  assign scale_prod = PB'(band_idx) * PB'(span_q);
  assign quo_try    = quo_q | (SB'(1) << cnt_q);
  assign quo_prod   = PB'(quo_try) * PB'(bands_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tsc_pkg::LN_IDLE,
      tsc_pkg::LN_DONE: begin
        if (req_i.start) state_d = tsc_pkg::LN_PREP;
      end
      tsc_pkg::LN_PREP: begin
        state_d = tsc_pkg::LN_SEARCH;
      end
      tsc_pkg::LN_SEARCH: begin
        if (cnt_q == '0) state_d = tsc_pkg::LN_SCALE;
      end
      tsc_pkg::LN_SCALE: begin
        state_d = tsc_pkg::LN_DIVIDE;
      end
      tsc_pkg::LN_DIVIDE: begin
        if (cnt_q == '0) state_d = tsc_pkg::LN_DONE;
      end
      default: begin
        state_d = tsc_pkg::LN_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsc_pkg::LN_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      tsc_pkg::LN_IDLE,
      tsc_pkg::LN_DONE: begin
        if (req_i.start) begin
          neg_q     <= req_i.value[SB-1];
          mag_q     <= mag_in;
          incline_q <= req_i.incline;
          span_q    <= req_i.span;
          bands_q   <= req_i.bands;
        end
      end
      tsc_pkg::LN_PREP: begin
        target_q <= target_prod;
        band_q   <= '0;
        cnt_q    <= CB'(BB - 1);
      end
      tsc_pkg::LN_SEARCH: begin
        if (band_prod < target_q) band_q <= band_try;
        cnt_q <= cnt_q - CB'(1);
      end
      tsc_pkg::LN_SCALE: begin
        scaled_q <= scale_prod;
        quo_q    <= '0;
        cnt_q    <= CB'(SB - 1);
      end
      tsc_pkg::LN_DIVIDE: begin
        if (quo_prod <= scaled_q) quo_q <= quo_try;
        cnt_q <= cnt_q - CB'(1);
      end
      default: begin
      end
    endcase
  end

  // Outputs: saturated, signed band level once finished.
  assign level_mag = (quo_q > SB'(tsc_pkg::SampleMax)) ? SB'(tsc_pkg::SampleMax) : quo_q;

  always_comb begin
    rsp_o.done  = (state_q == tsc_pkg::LN_DONE);
    rsp_o.level = '0;
    if (mag_q != '0) begin
      rsp_o.level = neg_q ? -tsc_pkg::sample_t'(level_mag) : tsc_pkg::sample_t'(level_mag);
    end
  end

endmodule

/* hdl/tilt_sensor_conditioner_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt sensor conditioner top level
// Conditions three-axis tilt samples and derives a band level per axis.
// ----------------------------------------------------------------------------
// Each input beat carries x, y and z in 1/64 degree and a read-ok flag; each
// produces one output beat with the conditioned angles, three band levels and
// the held / levels-valid flags. One sample is in flight at a time and passes
// through two conditioning stages, then three band lanes that run in parallel,
// each running its band search and then its quotient search. A finished
// result waits in the output register while the next sample is already
// accepted. Configuration must be written through the plain write port only
// while no sample is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module tilt_sensor_conditioner_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [tsc_pkg::InDataBits-1:0]      s_axis_tdata,  // raw_x, raw_y, raw_z
  input  logic [0:0]                          s_axis_tuser,  // read_ok
  // Output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [tsc_pkg::OutDataBits-1:0]     m_axis_tdata,  // out_x, out_y, out_z,
                                                             // level_x, level_y, level_z
  output logic [1:0]                          m_axis_tuser,  // held, levels_valid
  // Configuration writes
  input  logic                                cfg_we_i,
  input  logic [tsc_pkg::CfgAddrBits-1:0]     cfg_addr_i,
  input  logic [tsc_pkg::CfgDataBits-1:0]     cfg_wdata_i
);

  localparam int SB = tsc_pkg::SampleBits;
  localparam int NA = tsc_pkg::NumAxes;
  localparam int BB = tsc_pkg::BandBits;
  localparam int CW = tsc_pkg::CountBits;

  // Configuration registers.
  logic [tsc_pkg::CfgDataBits-1:0] offsets_q;
  logic [tsc_pkg::CfgDataBits-1:0] deadzones_q;
  logic [tsc_pkg::CfgDataBits-1:0] step_limits_q;
  logic [SB-1:0]                   freeze_q;
  logic [NA-1:0]                   flip_q;
  logic [tsc_pkg::CfgDataBits-1:0] incline_q;
  logic [CW-1:0]                   divide_q;
  logic [tsc_pkg::CfgDataBits-1:0] span_q;

  tsc_pkg::top_state_e state_q, state_d;

  tsc_pkg::sample_t    in_q [NA];
  logic                read_ok_q;
  tsc_pkg::cond_ctrl_t cond_ctrl;
  tsc_pkg::sample_t    result [NA];
  tsc_pkg::band_req_t  lane_req [NA];
  tsc_pkg::band_rsp_t  lane_rsp [NA];
  logic                lane_start;
  logic                lanes_done;
  logic [BB-1:0]       bands_eff;
  logic                levels_valid;
  logic                in_take;
  logic                out_load;

  logic                            m_valid_q;
  logic [tsc_pkg::OutDataBits-1:0] m_data_q;
  logic [1:0]                      m_user_q;

  // Configuration write port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offsets_q     <= '0;
      deadzones_q   <= '0;
      step_limits_q <= tsc_pkg::StepLimitsReset;
      freeze_q      <= '0;
      flip_q        <= '0;
      incline_q     <= '0;
      divide_q      <= tsc_pkg::DivideCountReset;
      span_q        <= tsc_pkg::OutputSpanReset;
    end else if (cfg_we_i) begin
      case (tsc_pkg::cfg_idx_e'(cfg_addr_i))
        tsc_pkg::CFG_AXIS_OFFSETS:     offsets_q     <= cfg_wdata_i;
        tsc_pkg::CFG_DEADZONES:        deadzones_q   <= cfg_wdata_i;
        tsc_pkg::CFG_STEP_LIMITS:      step_limits_q <= cfg_wdata_i;
        tsc_pkg::CFG_FREEZE_THRESHOLD: freeze_q      <= cfg_wdata_i[SB-1:0];
        tsc_pkg::CFG_FLIP_MASK:        flip_q        <= cfg_wdata_i[NA-1:0];
        tsc_pkg::CFG_MAX_INCLINE:      incline_q     <= cfg_wdata_i;
        tsc_pkg::CFG_DIVIDE_COUNT:     divide_q      <= cfg_wdata_i[CW-1:0];
        tsc_pkg::CFG_OUTPUT_SPAN:      span_q        <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Band count clamped to 1..MaxBands; quantizer off when no incline is set.
  always_comb begin
    if (divide_q == '0) begin
      bands_eff = BB'(1);
    end else if (divide_q > CW'(tsc_pkg::MaxBands)) begin
      bands_eff = BB'(tsc_pkg::MaxBands);
    end else begin
      bands_eff = BB'(divide_q);
    end
  end

  assign levels_valid = |incline_q;

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tsc_pkg::ST_IDLE:  if (s_axis_tvalid) state_d = tsc_pkg::ST_COND;
      tsc_pkg::ST_COND:  state_d = tsc_pkg::ST_LIMIT;
      tsc_pkg::ST_LIMIT: state_d = tsc_pkg::ST_START;
      tsc_pkg::ST_START: state_d = tsc_pkg::ST_WAIT;
      tsc_pkg::ST_WAIT:  if (lanes_done) state_d = tsc_pkg::ST_OUT;
      tsc_pkg::ST_OUT:   if (!m_valid_q || m_axis_tready) state_d = tsc_pkg::ST_IDLE;
      default:           state_d = tsc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready       = 1'b0;
    cond_ctrl.stage1_en = 1'b0;
    cond_ctrl.stage2_en = 1'b0;
    lane_start          = 1'b0;
    out_load            = 1'b0;
    case (state_q)
      tsc_pkg::ST_IDLE:  s_axis_tready = 1'b1;
      tsc_pkg::ST_COND:  cond_ctrl.stage1_en = 1'b1;
      tsc_pkg::ST_LIMIT: cond_ctrl.stage2_en = 1'b1;
      tsc_pkg::ST_START: lane_start = 1'b1;
      tsc_pkg::ST_OUT:   out_load = !m_valid_q || m_axis_tready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Input beat capture.
  assign in_take = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      for (int a = 0; a < NA; a++) begin
        in_q[a] <= tsc_pkg::sample_t'(s_axis_tdata[SB*a +: SB]);
      end
      read_ok_q <= s_axis_tuser[0];
    end
  end

  // Conditioning front end.
  tsc_cond u_cond (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (cond_ctrl),
    .sample_i      (in_q),
    .read_ok_i     (read_ok_q),
    .offsets_i     (offsets_q),
    .deadzones_i   (deadzones_q),
    .step_limits_i (step_limits_q),
    .freeze_i      (freeze_q),
    .flip_i        (flip_q),
    .result_o      (result)
  );

  // One band lane per axis.
  for (genvar a = 0; a < NA; a++) begin : g_lane
    assign lane_req[a].start   = lane_start;
    assign lane_req[a].value   = result[a];
    assign lane_req[a].incline = incline_q[SB*a +: SB];
    assign lane_req[a].span    = span_q[SB*a +: SB];
    assign lane_req[a].bands   = bands_eff;

    tsc_band_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (lane_req[a]),
      .rsp_o  (lane_rsp[a])
    );
  end

  // Merge: all lanes start together and finish together.
  assign lanes_done = lane_rsp[0].done && lane_rsp[1].done && lane_rsp[2].done;

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {levels_valid ? lane_rsp[2].level : tsc_pkg::sample_t'('0),
                   levels_valid ? lane_rsp[1].level : tsc_pkg::sample_t'('0),
                   levels_valid ? lane_rsp[0].level : tsc_pkg::sample_t'('0),
                   result[2], result[1], result[0]};
      m_user_q <= {levels_valid, !read_ok_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule
